### rtl/meter_mode_c_frame_parser_core_assert.svh
// assertion macros shared by the frame parser rtl
`ifndef METER_MODE_C_FRAME_PARSER_CORE_ASSERT_SVH
`define METER_MODE_C_FRAME_PARSER_CORE_ASSERT_SVH

// expects clk and rst_n in scope
`define MCFP_CHECK(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`define MCFP_CHECK_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define MCFP_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mcfp_pkg.sv
// types and constants of the meter frame parser
`default_nettype none

package mcfp_pkg;

    localparam int CHAR_W      = 7;
    localparam int HDR_LEN     = 4;
    localparam int WIDE_LEN    = 16;
    localparam int WIDE_END    = HDR_LEN + 1 + WIDE_LEN;
    localparam int MAX_RUN     = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CH_SOH   = 7'h01;
    localparam logic [CHAR_W-1:0] CH_STX   = 7'h02;
    localparam logic [CHAR_W-1:0] CH_ETX   = 7'h03;
    localparam logic [CHAR_W-1:0] CH_ACK   = 7'h06;
    localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
    localparam logic [CHAR_W-1:0] CH_NAK   = 7'h15;
    localparam logic [CHAR_W-1:0] CH_END   = 7'h21;
    localparam logic [CHAR_W-1:0] CH_START = 7'h2F;
    localparam logic [CHAR_W-1:0] CH_BREAK = 7'h42;
    localparam logic [CHAR_W-1:0] CH_WIDE  = 7'h5C;

    // first payload position in the buffer for each frame shape
    localparam logic [2:0] START_DATA  = 3'd0;
    localparam logic [2:0] START_CMD   = 3'd2;
    localparam logic [2:0] START_IDENT = 3'd4;
    localparam logic [2:0] START_WIDE  = 3'd5;

    typedef enum logic [2:0] {
        KIND_IDENT = 3'd0,
        KIND_DATA  = 3'd1,
        KIND_ACK   = 3'd2,
        KIND_NAK   = 3'd3,
        KIND_CMD   = 3'd4,
        KIND_BREAK = 3'd5,
        KIND_OVF   = 3'd6
    } frame_kind_t;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_HDR     = 4'd1,
        PH_WIDECHK = 4'd2,
        PH_WIDESET = 4'd3,
        PH_TEXT    = 4'd4,
        PH_DATA    = 4'd5,
        PH_CMD     = 4'd6,
        PH_CMDTYPE = 4'd7,
        PH_STX     = 4'd8,
        PH_CR      = 4'd9,
        PH_LF      = 4'd10,
        PH_ETX     = 4'd11,
        PH_BCC     = 4'd12
    } phase_t;

    typedef enum logic {
        B_IDLE = 1'b0,
        B_LOAD = 1'b1
    } back_state_t;

    // one completed frame, waiting to be played out
    typedef struct packed {
        frame_kind_t       kind;
        logic [23:0]       manufacturer;
        logic [CHAR_W-1:0] baud_char;
        logic              wide_flag;
        logic [CHAR_W-1:0] command;
        logic [CHAR_W-1:0] command_type;
        logic [2:0]        start;
        logic [6:0]        count;
    } desc_t;

    typedef struct packed {
        logic [2:0]        frame_kind;
        logic [23:0]       manufacturer;
        logic [CHAR_W-1:0] baud_char;
        logic              wide_flag;
        logic [CHAR_W-1:0] command;
        logic [CHAR_W-1:0] command_type;
        logic [CHAR_W-1:0] payload_byte;
        logic [5:0]        payload_index;
        logic              payload_valid;
        logic              in_wide_setting;
        logic              last;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic queue_full;
        logic buffer_busy;
    } front_hold_t;

endpackage

`default_nettype wire

### rtl/mcfp_in_if.sv
// received byte channel
`default_nettype none

interface mcfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/mcfp_out_if.sv
// result word channel
`default_nettype none

interface mcfp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  frame_kind;
    logic [23:0] manufacturer;
    logic [6:0]  baud_char;
    logic        wide_flag;
    logic [6:0]  command;
    logic [6:0]  command_type;
    logic [6:0]  payload_byte;
    logic [5:0]  payload_index;
    logic        payload_valid;
    logic        in_wide_setting;
    logic        last;

    modport source (
        output valid, output frame_kind, output manufacturer, output baud_char,
        output wide_flag, output command, output command_type, output payload_byte,
        output payload_index, output payload_valid, output in_wide_setting,
        output last, input ready
    );
    modport sink (
        input valid, input frame_kind, input manufacturer, input baud_char,
        input wide_flag, input command, input command_type, input payload_byte,
        input payload_index, input payload_valid, input in_wide_setting,
        input last, output ready
    );
endinterface

`default_nettype wire

### rtl/mcfp_ram.sv
// generic single write, single read ram with registered read
`default_nettype none

module mcfp_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/mcfp_queue.sv
// short queue of completed frame descriptors
`default_nettype none

module mcfp_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire mcfp_pkg::desc_t   push_desc,
    input  wire logic              pop,
    output mcfp_pkg::desc_t        head,
    output mcfp_pkg::q_status_t    status
);

    localparam int QD  = mcfp_pkg::QUEUE_DEPTH;
    localparam int PW  = (QD > 1) ? $clog2(QD) : 1;
    localparam int LW  = $clog2(QD + 1);

    mcfp_pkg::desc_t entries_reg [QD];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]   level_reg, level_next;

    // depth is a power of two, so pointers simply wrap
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign head         = entries_reg[rd_ptr_reg];
    assign status.full  = (level_reg == LW'(QD));
    assign status.empty = (level_reg == '0);

endmodule

`default_nettype wire

### rtl/mcfp_front.sv
// front end: takes bytes, tracks framing, fills the buffer, queues finished frames
`default_nettype none

module mcfp_front #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    mcfp_in_if.sink                              rx,
    input  wire mcfp_pkg::front_hold_t           hold,
    output logic                                 buf_wr_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0]      buf_wr_addr,
    output logic [mcfp_pkg::CHAR_W-1:0]          buf_wr_data,
    output logic                                 push,
    output mcfp_pkg::desc_t                      push_desc
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
    localparam int EXT_W  = (FILL_W > 7) ? FILL_W : 7;

    mcfp_pkg::phase_t      phase_reg, phase_next;
    mcfp_pkg::frame_kind_t service_reg, service_next;
    logic                  wide_reg, wide_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [mcfp_pkg::CHAR_W-1:0] hdr_reg [mcfp_pkg::HDR_LEN];

    logic [mcfp_pkg::CHAR_W-1:0] c;
    logic              acc;
    logic              ready_int;
    logic              writes_phase;
    logic              store;
    logic              clear_fill;
    logic              full;
    logic [FILL_W-1:0] fill_inc;
    mcfp_pkg::desc_t   etx_desc, ident_desc, simple_desc;

    assign c        = rx.rx_byte[mcfp_pkg::CHAR_W-1:0];
    assign acc      = rx.valid && ready_int;
    assign full     = (fill_reg == FILL_W'(BUFFER_DEPTH));
    assign fill_inc = fill_reg + 1'b1;
    assign rx.ready = ready_int;

    function automatic logic [6:0] run_count(input logic [FILL_W-1:0] fill,
                                             input logic [2:0] start);
        logic [EXT_W-1:0] diff;
        diff = EXT_W'(fill) - EXT_W'(start);
        return (diff > EXT_W'(mcfp_pkg::MAX_RUN)) ? 7'(mcfp_pkg::MAX_RUN) : diff[6:0];
    endfunction

    // descriptors that a completing frame may push
    always_comb
    begin
        simple_desc = '0;

        ident_desc              = '0;
        ident_desc.kind         = mcfp_pkg::KIND_IDENT;
        ident_desc.manufacturer = {hdr_reg[0], 1'b0, hdr_reg[1], 1'b0, hdr_reg[2]} >> 0;
        ident_desc.manufacturer = {1'b0, hdr_reg[0], 1'b0, hdr_reg[1], 1'b0, hdr_reg[2]};
        ident_desc.baud_char    = hdr_reg[3];
        ident_desc.wide_flag    = wide_reg;
        ident_desc.start        = wide_reg ? mcfp_pkg::START_WIDE : mcfp_pkg::START_IDENT;
        ident_desc.count        = run_count(fill_reg, ident_desc.start);

        etx_desc = '0;
        case (service_reg)
            mcfp_pkg::KIND_BREAK:
            begin
                etx_desc.kind         = mcfp_pkg::KIND_BREAK;
                etx_desc.command      = hdr_reg[0];
                etx_desc.command_type = hdr_reg[1];
            end
            mcfp_pkg::KIND_CMD:
            begin
                etx_desc.kind         = mcfp_pkg::KIND_CMD;
                etx_desc.command      = hdr_reg[0];
                etx_desc.command_type = hdr_reg[1];
                etx_desc.start        = mcfp_pkg::START_CMD;
                etx_desc.count        = run_count(fill_reg, mcfp_pkg::START_CMD);
            end
            default:
            begin
                etx_desc.kind  = mcfp_pkg::KIND_DATA;
                etx_desc.start = mcfp_pkg::START_DATA;
                etx_desc.count = run_count(fill_reg, mcfp_pkg::START_DATA);
            end
        endcase
    end

    // outputs: buffer writes, descriptor pushes, ready
    always_comb
    begin
        store        = 1'b0;
        push         = 1'b0;
        push_desc    = simple_desc;
        writes_phase = 1'b0;
        unique case (phase_reg)
            mcfp_pkg::PH_HDR, mcfp_pkg::PH_WIDESET,
            mcfp_pkg::PH_CMD, mcfp_pkg::PH_CMDTYPE:
            begin
                writes_phase = 1'b1;
                store        = acc;
            end
            mcfp_pkg::PH_WIDECHK, mcfp_pkg::PH_TEXT:
            begin
                writes_phase = 1'b1;
                if (c != mcfp_pkg::CH_CR)
                begin
                    if (!full)
                    begin
                        store = acc;
                    end
                    else
                    begin
                        push           = acc;
                        push_desc.kind = mcfp_pkg::KIND_OVF;
                    end
                end
            end
            mcfp_pkg::PH_DATA:
            begin
                writes_phase = 1'b1;
                if (c == mcfp_pkg::CH_ETX)
                begin
                    push      = acc;
                    push_desc = etx_desc;
                end
                else if (c != mcfp_pkg::CH_END)
                begin
                    if (!full)
                    begin
                        store = acc;
                    end
                    else
                    begin
                        push           = acc;
                        push_desc.kind = mcfp_pkg::KIND_OVF;
                    end
                end
            end
            mcfp_pkg::PH_LF:
            begin
                if (c == mcfp_pkg::CH_LF && service_reg == mcfp_pkg::KIND_IDENT)
                begin
                    push      = acc;
                    push_desc = ident_desc;
                end
            end
            mcfp_pkg::PH_ETX:
            begin
                if (c == mcfp_pkg::CH_ETX)
                begin
                    push      = acc;
                    push_desc = etx_desc;
                end
            end
            mcfp_pkg::PH_STX, mcfp_pkg::PH_CR, mcfp_pkg::PH_BCC:
            begin
                store = 1'b0;
            end
            default:
            begin
                // hunting, also any unused phase code
                if (c == mcfp_pkg::CH_ACK)
                begin
                    push           = acc;
                    push_desc.kind = mcfp_pkg::KIND_ACK;
                end
                else if (c == mcfp_pkg::CH_NAK)
                begin
                    push           = acc;
                    push_desc.kind = mcfp_pkg::KIND_NAK;
                end
            end
        endcase
    end

    // a byte in a buffer-writing phase waits while an earlier frame is still read out of the buffer
    assign ready_int   = !hold.queue_full && !(hold.buffer_busy && writes_phase);
    assign buf_wr_en   = store;
    assign buf_wr_addr = fill_reg[ADDR_W-1:0];
    assign buf_wr_data = c;

    // next phase
    always_comb
    begin
        phase_next   = phase_reg;
        service_next = service_reg;
        wide_next    = wide_reg;
        clear_fill   = 1'b0;
        if (acc)
        begin
            unique case (phase_reg)
                mcfp_pkg::PH_HDR:
                begin
                    if (fill_inc == FILL_W'(mcfp_pkg::HDR_LEN))
                    begin
                        phase_next = mcfp_pkg::PH_WIDECHK;
                    end
                end
                mcfp_pkg::PH_WIDESET:
                begin
                    if (fill_inc == FILL_W'(mcfp_pkg::WIDE_END))
                    begin
                        phase_next = mcfp_pkg::PH_TEXT;
                    end
                end
                mcfp_pkg::PH_WIDECHK:
                begin
                    if (c == mcfp_pkg::CH_WIDE)
                    begin
                        wide_next  = 1'b1;
                        phase_next = mcfp_pkg::PH_WIDESET;
                    end
                    else if (c == mcfp_pkg::CH_CR)
                    begin
                        phase_next = mcfp_pkg::PH_LF;
                    end
                    else if (full)
                    begin
                        clear_fill = 1'b1;
                        phase_next = mcfp_pkg::PH_HUNT;
                    end
                    else
                    begin
                        phase_next = mcfp_pkg::PH_TEXT;
                    end
                end
                mcfp_pkg::PH_TEXT:
                begin
                    if (c == mcfp_pkg::CH_CR)
                    begin
                        phase_next = mcfp_pkg::PH_LF;
                    end
                    else if (full)
                    begin
                        clear_fill = 1'b1;
                        phase_next = mcfp_pkg::PH_HUNT;
                    end
                end
                mcfp_pkg::PH_DATA:
                begin
                    if (c == mcfp_pkg::CH_END)
                    begin
                        phase_next = mcfp_pkg::PH_CR;
                    end
                    else if (c == mcfp_pkg::CH_ETX)
                    begin
                        clear_fill = 1'b1;
                        phase_next = mcfp_pkg::PH_BCC;
                    end
                    else if (full)
                    begin
                        clear_fill = 1'b1;
                        phase_next = mcfp_pkg::PH_HUNT;
                    end
                end
                mcfp_pkg::PH_CMD:
                begin
                    service_next = (c == mcfp_pkg::CH_BREAK) ? mcfp_pkg::KIND_BREAK
                                                             : mcfp_pkg::KIND_CMD;
                    phase_next   = mcfp_pkg::PH_CMDTYPE;
                end
                mcfp_pkg::PH_CMDTYPE:
                begin
                    phase_next = (service_reg == mcfp_pkg::KIND_BREAK) ? mcfp_pkg::PH_ETX
                                                                        : mcfp_pkg::PH_STX;
                end
                mcfp_pkg::PH_STX:
                begin
                    if (c == mcfp_pkg::CH_STX)
                    begin
                        phase_next = mcfp_pkg::PH_DATA;
                    end
                    else
                    begin
                        clear_fill = 1'b1;
                        phase_next = mcfp_pkg::PH_HUNT;
                    end
                end
                mcfp_pkg::PH_CR:
                begin
                    if (c == mcfp_pkg::CH_CR)
                    begin
                        phase_next = mcfp_pkg::PH_LF;
                    end
                    else
                    begin
                        clear_fill = 1'b1;
                        phase_next = mcfp_pkg::PH_HUNT;
                    end
                end
                mcfp_pkg::PH_LF:
                begin
                    if (c == mcfp_pkg::CH_LF && service_reg == mcfp_pkg::KIND_DATA)
                    begin
                        phase_next = mcfp_pkg::PH_ETX;
                    end
                    else
                    begin
                        clear_fill = 1'b1;
                        phase_next = mcfp_pkg::PH_HUNT;
                    end
                end
                mcfp_pkg::PH_ETX:
                begin
                    clear_fill = 1'b1;
                    phase_next = (c == mcfp_pkg::CH_ETX) ? mcfp_pkg::PH_BCC
                                                         : mcfp_pkg::PH_HUNT;
                end
                mcfp_pkg::PH_BCC:
                begin
                    clear_fill = 1'b1;
                    phase_next = mcfp_pkg::PH_HUNT;
                end
                default:
                begin
                    clear_fill = 1'b1;
                    phase_next = mcfp_pkg::PH_HUNT;
                    if (c == mcfp_pkg::CH_START)
                    begin
                        service_next = mcfp_pkg::KIND_IDENT;
                        wide_next    = 1'b0;
                        phase_next   = mcfp_pkg::PH_HDR;
                    end
                    else if (c == mcfp_pkg::CH_STX)
                    begin
                        service_next = mcfp_pkg::KIND_DATA;
                        phase_next   = mcfp_pkg::PH_DATA;
                    end
                    else if (c == mcfp_pkg::CH_SOH)
                    begin
                        phase_next = mcfp_pkg::PH_CMD;
                    end
                end
            endcase
        end
        if (clear_fill)
        begin
            fill_next = '0;
        end
        else if (store)
        begin
            fill_next = fill_inc;
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= mcfp_pkg::PH_HUNT;
            service_reg <= mcfp_pkg::KIND_IDENT;
            wide_reg    <= 1'b0;
            fill_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            service_reg <= service_next;
            wide_reg    <= wide_next;
            fill_reg    <= fill_next;
        end
    end

    // shadow copy of the first header characters, written alongside the buffer
    always_ff @(posedge clk)
    begin
        if (store && fill_reg < FILL_W'(mcfp_pkg::HDR_LEN))
        begin
            hdr_reg[fill_reg[1:0]] <= c;
        end
    end

endmodule

`default_nettype wire

### rtl/mcfp_back.sv
// back end: plays a queued frame out as a run of result words
`default_nettype none

module mcfp_back #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mcfp_pkg::desc_t                 head,
    input  wire mcfp_pkg::q_status_t             q_status,
    output logic                                 pop,
    output logic                                 rd_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0]      rd_addr,
    input  wire logic [mcfp_pkg::CHAR_W-1:0]     rd_data,
    output logic                                 busy,
    mcfp_out_if.source                           result
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int SUM_W  = (ADDR_W > 7) ? ADDR_W : 7;

    mcfp_pkg::back_state_t state_reg, state_next;
    mcfp_pkg::desc_t       cur_reg;
    mcfp_pkg::result_t     out_reg, res_next;
    logic [6:0]            k_reg, k_next;
    logic                  out_valid_reg, out_valid_next;

    logic       slot_free;
    logic       load;
    logic       empty_run;
    logic       is_last;
    logic [6:0] run_len;
    logic [6:0] k_inc;

    assign slot_free = !out_valid_reg || result.ready;
    assign empty_run = (cur_reg.count == '0);
    assign run_len   = empty_run ? 7'd1 : cur_reg.count;
    assign k_inc     = k_reg + 1'b1;
    assign is_last   = (k_inc == run_len);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcfp_pkg::B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = mcfp_pkg::B_LOAD;
                end
            end
            mcfp_pkg::B_LOAD:
            begin
                if (slot_free && is_last)
                begin
                    state_next = mcfp_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = mcfp_pkg::B_IDLE;
            end
        endcase
    end

    // read data is held until the word built from it goes out
    always_comb
    begin
        pop     = 1'b0;
        load    = 1'b0;
        rd_en   = 1'b0;
        rd_addr = ADDR_W'(SUM_W'(cur_reg.start) + SUM_W'(k_inc));
        unique case (state_reg)
            mcfp_pkg::B_IDLE:
            begin
                pop     = !q_status.empty;
                rd_en   = !q_status.empty;
                rd_addr = ADDR_W'(head.start);
            end
            mcfp_pkg::B_LOAD:
            begin
                load  = slot_free;
                rd_en = slot_free && !is_last;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res_next.frame_kind      = cur_reg.kind;
        res_next.manufacturer    = cur_reg.manufacturer;
        res_next.baud_char       = cur_reg.baud_char;
        res_next.wide_flag       = cur_reg.wide_flag;
        res_next.command         = cur_reg.command;
        res_next.command_type    = cur_reg.command_type;
        res_next.payload_byte    = empty_run ? '0 : rd_data;
        res_next.payload_index   = k_reg[5:0];
        res_next.payload_valid   = !empty_run;
        res_next.in_wide_setting = cur_reg.wide_flag && !empty_run
                                   && (k_reg < 7'(mcfp_pkg::WIDE_LEN));
        res_next.last            = is_last;

        k_next = k_reg;
        if (pop)
        begin
            k_next = '0;
        end
        else if (load)
        begin
            k_next = k_inc;
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcfp_pkg::B_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        if (load)
        begin
            out_reg <= res_next;
        end
    end

    assign busy                   = (state_reg != mcfp_pkg::B_IDLE);
    assign result.valid           = out_valid_reg;
    assign result.frame_kind      = out_reg.frame_kind;
    assign result.manufacturer    = out_reg.manufacturer;
    assign result.baud_char       = out_reg.baud_char;
    assign result.wide_flag       = out_reg.wide_flag;
    assign result.command         = out_reg.command;
    assign result.command_type    = out_reg.command_type;
    assign result.payload_byte    = out_reg.payload_byte;
    assign result.payload_index   = out_reg.payload_index;
    assign result.payload_valid   = out_reg.payload_valid;
    assign result.in_wide_setting = out_reg.in_wide_setting;
    assign result.last            = out_reg.last;

endmodule

`default_nettype wire

### rtl/meter_mode_c_frame_parser_core.sv
// top level of the meter mode c frame parser
// Takes one received character per word (bit 7, the parity bit, is dropped) and
// recognises identification, ack, nak, data, command and break frames. Frame
// characters go into a BUFFER_DEPTH-entry buffer ram; a finished frame is handed
// through a two-entry descriptor queue to the output side, which first fetches
// the first character and then sends one result word per cycle while the sink
// is ready, at most 64 words a frame.
// While a frame is still being read out of the buffer, a byte in a phase that
// writes the buffer waits (ready low); bytes in other phases, such as the bcc
// after etx or the opening character of the next frame, keep flowing. Ack and
// nak results need no buffer and only wait for queue space, unlike overflow.
`default_nettype none

`include "meter_mode_c_frame_parser_core_assert.svh"

module meter_mode_c_frame_parser_core #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mcfp_in_if.sink     rx,
    mcfp_out_if.source  result
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);

    logic                          buf_wr_en;
    logic [ADDR_W-1:0]             buf_wr_addr;
    logic [mcfp_pkg::CHAR_W-1:0]   buf_wr_data;
    logic                          buf_rd_en;
    logic [ADDR_W-1:0]             buf_rd_addr;
    logic [mcfp_pkg::CHAR_W-1:0]   buf_rd_data;
    logic                          push;
    logic                          pop;
    logic                          back_busy;
    mcfp_pkg::desc_t               push_desc;
    mcfp_pkg::desc_t               head;
    mcfp_pkg::q_status_t           q_status;
    mcfp_pkg::front_hold_t         hold;

    assign hold.queue_full  = q_status.full;
    assign hold.buffer_busy = back_busy || !q_status.empty;

    mcfp_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx),
        .hold        (hold),
        .buf_wr_en   (buf_wr_en),
        .buf_wr_addr (buf_wr_addr),
        .buf_wr_data (buf_wr_data),
        .push        (push),
        .push_desc   (push_desc)
    );

    mcfp_ram #(
        .WIDTH (mcfp_pkg::CHAR_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_buffer (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (buf_wr_addr),
        .wr_data (buf_wr_data),
        .rd_en   (buf_rd_en),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    mcfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    mcfp_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .rd_en    (buf_rd_en),
        .rd_addr  (buf_rd_addr),
        .rd_data  (buf_rd_data),
        .busy     (back_busy),
        .result   (result)
    );

    `MCFP_CHECK(a_no_write_during_readout, !(buf_wr_en && (back_busy || !q_status.empty)), "buffer written while a frame is read out")
    `MCFP_CHECK_IMPL(a_push_has_room, push, !q_status.full, "descriptor pushed into a full queue")
    `MCFP_CHECK_NEXT(a_run_keeps_kind, result.valid && result.ready && !result.last, result.frame_kind == $past(result.frame_kind), "frame kind changed inside a run")
    `MCFP_CHECK_IMPL(a_empty_run_is_last, result.valid && !result.payload_valid, result.last, "empty frame word not marked last")

endmodule

`default_nettype wire
